/* rtl/gpp_pkg.sv */
package gpp_pkg;

  // Fixed field widths.
  localparam int VALUE_BITS    = 24;
  localparam int POS_BITS      = 12;
  localparam int MD_BITS       = 13;
  localparam int DC_BITS       = 7;
  localparam int CNT_BITS      = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Threshold after reset: 0.1 in Q8.15.
  localparam logic signed [VALUE_BITS-1:0] THR_RESET = 24'sd3277;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_WINDOW,
    ST_BLOCK,
    ST_EMIT
  } gpp_state_t;

endpackage

/* rtl/gpp_ram.sv */
module gpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/greedy_peak_pick_with_suppression_unit.sv */
// Greedy peak picking with non-maximum suppression over one frame of
// correlation values.
// Input channel (in_valid/in_ready): one request carries one value; the value
// flagged by last_value closes the frame and starts selection. A value that
// arrives when MAX_LEN values are already held is dropped. Loading takes one
// cycle per value, with in_ready high back to back.
// Selection: each detection costs one scan of the stored frame through the
// single read port of the value memory, plus, when min_distance is non-zero
// and another scan follows, a window set-up step and the marking of the
// clipped suppression window, one marker write per cycle.
// Output channel (out_valid/out_ready): results leave in ascending position
// order from a final walk of the picked markers; the walk pauses after each
// result and resumes at the next position. An empty frame gives one request
// with found low. in_ready stays low from the closing value until the last
// result is loaded into the output register. A stalled receiver simply holds
// the output register and pauses the walk. Reset clears the control state,
// min_distance and detect_count, and sets the threshold to THR_RESET; the
// suppression markers are cleared as each value is loaded, so no clearing
// pass is needed. Configure only while in_ready is high and no result waits.
module greedy_peak_pick_with_suppression_unit #(
  parameter int MAX_LEN    = 4096,
  parameter int MAX_DETECT = 64
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [gpp_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [gpp_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [gpp_pkg::VALUE_BITS-1:0]    corr_value,
  input  logic                                     last_value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [gpp_pkg::POS_BITS-1:0]             position,
  output logic signed [gpp_pkg::VALUE_BITS-1:0]    coeff,
  output logic                                     found,
  output logic                                     capped,
  output logic                                     last_result
);
  import gpp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = AW + 1;
  localparam int WW = ((AW > MD_BITS) ? AW : MD_BITS) + 1;

  // Configuration.
  logic [MD_BITS-1:0]           min_distance;
  logic [DC_BITS-1:0]           detect_count;
  logic signed [VALUE_BITS-1:0] threshold;

  // Control state.
  gpp_state_t           state, state_next;
  logic [LW-1:0]        load_count, load_count_next;
  logic [LW-1:0]        rd_ptr, rd_ptr_next;
  logic                 rd_pend, rd_pend_next;
  logic [AW-1:0]        rd_idx, rd_idx_next;
  logic                 have, have_next;
  logic [AW-1:0]        best_pos, best_pos_next;
  logic signed [VALUE_BITS-1:0] best_val, best_val_next;
  logic [CNT_BITS-1:0]  found_cnt, found_cnt_next;
  logic [CNT_BITS-1:0]  emit_cnt, emit_cnt_next;
  logic                 capped_flag, capped_flag_next;
  logic [LW-1:0]        win_ptr, win_ptr_next;
  logic [LW-1:0]        win_end, win_end_next;
  logic                 out_valid_next;

  // Output payload.
  logic [POS_BITS-1:0]          position_next;
  logic signed [VALUE_BITS-1:0] coeff_next;
  logic                         found_next, capped_next, last_result_next;

  // Memory ports.
  logic                  val_we, pk_we, bk_we;
  logic [AW-1:0]         val_waddr, pk_waddr, bk_waddr;
  logic                  pk_wdata, bk_wdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  pk_rdata, bk_rdata;
  logic signed [VALUE_BITS-1:0] val_q;

  // Window arithmetic.
  logic [WW-1:0]       best_w, md_w, win_sum;
  logic [CNT_BITS-1:0] found_inc;

  assign val_q     = val_rdata;
  assign in_ready  = (state == ST_LOAD);
  assign best_w    = WW'(best_pos);
  assign md_w      = WW'(min_distance);
  assign win_sum   = best_w + md_w;
  assign found_inc = found_cnt + CNT_BITS'(1);

  gpp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (corr_value),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (val_rdata)
  );

  gpp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_picked_ram (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (pk_rdata)
  );

  gpp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_blocked_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (bk_rdata)
  );

  always_comb begin
    state_next       = state;
    load_count_next  = load_count;
    rd_ptr_next      = rd_ptr;
    rd_pend_next     = rd_pend;
    rd_idx_next      = rd_idx;
    have_next        = have;
    best_pos_next    = best_pos;
    best_val_next    = best_val;
    found_cnt_next   = found_cnt;
    emit_cnt_next    = emit_cnt;
    capped_flag_next = capped_flag;
    win_ptr_next     = win_ptr;
    win_end_next     = win_end;
    out_valid_next   = out_valid && !out_ready;
    position_next    = position;
    coeff_next       = coeff;
    found_next       = found;
    capped_next      = capped;
    last_result_next = last_result;
    val_we    = 1'b0;
    val_waddr = load_count[AW-1:0];
    pk_we     = 1'b0;
    pk_waddr  = load_count[AW-1:0];
    pk_wdata  = 1'b0;
    bk_we     = 1'b0;
    bk_waddr  = load_count[AW-1:0];
    bk_wdata  = 1'b0;

    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          // Loading a value also clears both markers at its position.
          if (load_count < LW'(MAX_LEN)) begin
            val_we          = 1'b1;
            pk_we           = 1'b1;
            bk_we           = 1'b1;
            load_count_next = load_count + LW'(1);
          end
          if (last_value) begin
            state_next   = ST_SCAN;
            rd_ptr_next  = '0;
            rd_pend_next = 1'b0;
            have_next    = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        if (rd_ptr < load_count) begin
          rd_pend_next = 1'b1;
          rd_idx_next  = rd_ptr[AW-1:0];
          rd_ptr_next  = rd_ptr + LW'(1);
        end else begin
          rd_pend_next = 1'b0;
        end
        // Strict compare in ascending order keeps the lower index on a tie.
        if (rd_pend && !pk_rdata && !bk_rdata && (!have || (val_q > best_val))) begin
          have_next     = 1'b1;
          best_pos_next = rd_idx;
          best_val_next = val_q;
        end
        if ((rd_ptr == load_count) && !rd_pend) begin
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        rd_ptr_next   = '0;
        emit_cnt_next = '0;
        if (!have || ((detect_count == '0) && (best_val < threshold))) begin
          state_next = ST_EMIT;
        end else begin
          pk_we          = 1'b1;
          pk_waddr       = best_pos;
          pk_wdata       = 1'b1;
          found_cnt_next = found_inc;
          if ((detect_count != '0) && (found_inc >= detect_count)) begin
            state_next = ST_EMIT;
          end else if (found_inc >= CNT_BITS'(MAX_DETECT)) begin
            capped_flag_next = 1'b1;
            state_next       = ST_EMIT;
          end else if (min_distance != '0) begin
            state_next = ST_WINDOW;
          end else begin
            state_next   = ST_SCAN;
            rd_pend_next = 1'b0;
            have_next    = 1'b0;
          end
        end
      end

      ST_WINDOW: begin
        // The window is clipped to the loaded part of the frame.
        win_ptr_next = (best_w >= md_w) ? LW'(best_w - md_w) : '0;
        win_end_next = (win_sum > WW'(load_count)) ? load_count : LW'(win_sum);
        state_next   = ST_BLOCK;
      end

      ST_BLOCK: begin
        bk_we        = 1'b1;
        bk_waddr     = win_ptr[AW-1:0];
        bk_wdata     = 1'b1;
        win_ptr_next = win_ptr + LW'(1);
        if ((win_ptr + LW'(1)) == win_end) begin
          state_next   = ST_SCAN;
          rd_ptr_next  = '0;
          rd_pend_next = 1'b0;
          have_next    = 1'b0;
        end
      end

      ST_EMIT: begin
        if (found_cnt == '0) begin
          if (!out_valid) begin
            out_valid_next   = 1'b1;
            position_next    = '0;
            coeff_next       = '0;
            found_next       = 1'b0;
            capped_next      = 1'b0;
            last_result_next = 1'b1;
            state_next       = ST_LOAD;
            load_count_next  = '0;
            capped_flag_next = 1'b0;
          end
        end else begin
          // Walk the picked markers in ascending order; the walk pauses
          // while the output register is still occupied.
          if (!out_valid && (rd_ptr < load_count)) begin
            rd_pend_next = 1'b1;
            rd_idx_next  = rd_ptr[AW-1:0];
            rd_ptr_next  = rd_ptr + LW'(1);
          end else begin
            rd_pend_next = 1'b0;
          end
          if (rd_pend && pk_rdata) begin
            out_valid_next   = 1'b1;
            position_next    = POS_BITS'(rd_idx);
            coeff_next       = val_q;
            found_next       = 1'b1;
            capped_next      = capped_flag;
            last_result_next = ((emit_cnt + CNT_BITS'(1)) == found_cnt);
            emit_cnt_next    = emit_cnt + CNT_BITS'(1);
            rd_pend_next     = 1'b0;
            rd_ptr_next      = LW'(rd_idx) + LW'(1);
            if ((emit_cnt + CNT_BITS'(1)) == found_cnt) begin
              state_next       = ST_LOAD;
              load_count_next  = '0;
              found_cnt_next   = '0;
              capped_flag_next = 1'b0;
            end
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      load_count   <= '0;
      rd_ptr       <= '0;
      rd_pend      <= 1'b0;
      have         <= 1'b0;
      found_cnt    <= '0;
      emit_cnt     <= '0;
      capped_flag  <= 1'b0;
      out_valid    <= 1'b0;
      min_distance <= '0;
      detect_count <= '0;
      threshold    <= THR_RESET;
    end else begin
      state       <= state_next;
      load_count  <= load_count_next;
      rd_ptr      <= rd_ptr_next;
      rd_pend     <= rd_pend_next;
      have        <= have_next;
      found_cnt   <= found_cnt_next;
      emit_cnt    <= emit_cnt_next;
      capped_flag <= capped_flag_next;
      out_valid   <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_MIN_DISTANCE: min_distance <= cfg_data[MD_BITS-1:0];
          REG_DETECT_COUNT: detect_count <= cfg_data[DC_BITS-1:0];
          REG_THRESHOLD:    threshold    <= cfg_data[VALUE_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    best_pos    <= best_pos_next;
    best_val    <= best_val_next;
    win_ptr     <= win_ptr_next;
    win_end     <= win_end_next;
    position    <= position_next;
    coeff       <= coeff_next;
    found       <= found_next;
    capped      <= capped_next;
    last_result <= last_result_next;
  end

  // The detection count never passes the cap.
  a_found_cap: assert property (@(posedge clk) disable iff (rst)
    found_cnt <= CNT_BITS'(MAX_DETECT))
    else $error("detection count beyond cap");

  // A window being marked is never empty and ends inside the frame.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLOCK) |-> ((win_ptr < win_end) && (win_end <= load_count)))
    else $error("suppression window out of range");

  // A chosen candidate lies inside the loaded frame.
  a_best_in_frame: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DECIDE) && have) |-> (LW'(best_pos) < load_count))
    else $error("best candidate outside frame");

  // An empty-frame result is always the last of its frame.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> last_result)
    else $error("empty result not marked last");

endmodule

/* dv/greedy_peak_pick_with_suppression_unit_tb.sv */
`timescale 1ns / 100ps

module greedy_peak_pick_with_suppression_unit_tb;
  import gpp_pkg::*;

  localparam int FRAME_MAX   = 4096;
  localparam int PEAK_MAX    = 64;
  localparam int STALL_LIMIT = 200000;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 24'h800000;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 24'h7FFFFF;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } corr_item_t;

  typedef struct {
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] coeff;
    logic                         found;
    logic                         capped;
    logic                         last_result;
  } peak_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index = REG_MIN_DISTANCE;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] corr_value = '0;
  logic                         last_value = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [POS_BITS-1:0]          position;
  logic signed [VALUE_BITS-1:0] coeff;
  logic                         found;
  logic                         capped;
  logic                         last_result;

  greedy_peak_pick_with_suppression_unit #(
    .MAX_LEN    (FRAME_MAX),
    .MAX_DETECT (PEAK_MAX)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .corr_value  (corr_value),
    .last_value  (last_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .coeff       (coeff),
    .found       (found),
    .capped      (capped),
    .last_result (last_result)
  );

  // Pending correlation values and the peaks expected back from the block.
  corr_item_t corr_feed_q[$];
  peak_t      peak_q[$];

  // Own copy of the configuration and of the frame held by the block.
  int                           pred_min_dist = 0;
  int                           pred_detect_count = 0;
  logic signed [VALUE_BITS-1:0] pred_threshold = THR_RESET;
  logic signed [VALUE_BITS-1:0] frame_values [FRAME_MAX];
  bit                           blocked [FRAME_MAX];
  bit                           picked [FRAME_MAX];
  int                           frame_len = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int frames_closed = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  logic signed [VALUE_BITS-1:0] prev_value = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Greedy selection over the loaded frame, then results in position order.
  task automatic select_peaks();
    int                           n;
    int                           best;
    int                           lo;
    int                           hi;
    int                           i;
    int                           k;
    int                           hits[$];
    bit                           have;
    bit                           done;
    bit                           cap_hit;
    logic signed [VALUE_BITS-1:0] best_val;
    peak_t                        r;
    n = frame_len;
    cap_hit = 1'b0;
    done = 1'b0;
    best = 0;
    best_val = '0;
    while (!done) begin
      have = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!picked[i] && !blocked[i] && (!have || frame_values[i] > best_val)) begin
          have = 1'b1;
          best = i;
          best_val = frame_values[i];
        end
      end
      if (!have || (pred_detect_count == 0 && best_val < pred_threshold)) begin
        done = 1'b1;
      end else begin
        picked[best] = 1'b1;
        hits.insert(hits.size(), best);
        if (pred_detect_count != 0 && hits.size() >= pred_detect_count) begin
          done = 1'b1;
        end else if (hits.size() >= PEAK_MAX) begin
          cap_hit = 1'b1;
          done = 1'b1;
        end else if (pred_min_dist > 0) begin
          lo = (best - pred_min_dist < 0) ? 0 : best - pred_min_dist;
          hi = (best + pred_min_dist > n) ? n : best + pred_min_dist;
          for (k = lo; k < hi; k++) blocked[k] = 1'b1;
        end
      end
    end
    if (hits.size() == 0) begin
      r = '{position: '0, coeff: '0, found: 1'b0, capped: 1'b0, last_result: 1'b1};
      peak_q.insert(peak_q.size(), r);
    end else begin
      hits.sort();
      for (i = 0; i < hits.size(); i++) begin
        r.position    = hits[i][POS_BITS-1:0];
        r.coeff       = frame_values[hits[i]];
        r.found       = 1'b1;
        r.capped      = cap_hit;
        r.last_result = (i == hits.size() - 1);
        peak_q.insert(peak_q.size(), r);
      end
    end
    for (i = 0; i < n; i++) begin
      blocked[i] = 1'b0;
      picked[i] = 1'b0;
    end
    frame_len = 0;
    frames_closed++;
  endtask

  // Values beyond the frame capacity are dropped, but a last mark still counts.
  task automatic absorb_value(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
    if (frame_len < FRAME_MAX) begin
      frame_values[frame_len] = v;
      frame_len++;
    end
    if (is_last) select_peaks();
  endtask

  always @(posedge clk) begin : request_driver
    corr_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_value(corr_value, last_value);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (corr_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = corr_feed_q.pop_front();
          in_valid <= 1'b1;
          corr_value <= nxt.value;
          last_value <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    peak_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        results_checked++;
        if (peak_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result pos=%0d coeff=%0d found=%b",
                                    position, coeff, found));
        end else begin
          want = peak_q.pop_front();
          if (position !== want.position || coeff !== want.coeff || found !== want.found ||
              capped !== want.capped || last_result !== want.last_result) begin
            report_mismatch($sformatf(
              "exp pos=%0d coeff=%0d f=%b c=%b l=%b, got pos=%0d coeff=%0d f=%b c=%b l=%b",
              want.position, want.coeff, want.found, want.capped, want.last_result,
              position, coeff, found, capped, last_result));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sampled on the falling edge so the queues and handshakes have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (corr_feed_q.size() != 0 || in_valid || peak_q.size() != 0 || in_ready !== 1'b1);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MIN_DISTANCE: pred_min_dist = data[MD_BITS-1:0];
      REG_DETECT_COUNT: pred_detect_count = data[DC_BITS-1:0];
      REG_THRESHOLD:    pred_threshold = data[VALUE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int md, input int dc, input logic signed [VALUE_BITS-1:0] thr);
    wait_drained();
    write_reg(REG_MIN_DISTANCE, CFG_DATA_BITS'(md));
    write_reg(REG_DETECT_COUNT, CFG_DATA_BITS'(dc));
    write_reg(REG_THRESHOLD, thr);
    settings_used++;
  endtask

  task automatic queue_value(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
    corr_item_t it;
    it.value = v;
    it.last = is_last;
    corr_feed_q.insert(corr_feed_q.size(), it);
  endtask

  // Mostly full-range values, with extremes, near-threshold values and repeats for ties.
  function automatic logic signed [VALUE_BITS-1:0] pick_corr_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0: v = VAL_MAX;
      1: v = VAL_MIN;
      2: v = pred_threshold + $signed(VALUE_BITS'($urandom_range(4))) - 24'sd2;
      3: v = prev_value;
      default: v = VALUE_BITS'($urandom);
    endcase
    prev_value = v;
    return v;
  endfunction

  task automatic queue_frame(input int len);
    int i;
    for (i = 0; i < len; i++) queue_value(pick_corr_value(), i == len - 1);
  endtask

  initial begin : stimulus
    int phase;
    int queued;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: threshold mode at 0.1, no suppression. Covers ties,
    // a value equal to the threshold, field extremes and empty frames.
    queue_value(24'sd3277, 1'b0);
    queue_value(24'sd3276, 1'b0);
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b0);
    queue_value(24'sd100000, 1'b0);
    queue_value(24'sd100000, 1'b1);
    queue_value(VAL_MIN, 1'b1);
    queue_value(24'sd0, 1'b0);
    queue_value(24'sd3276, 1'b1);

    // Fixed count with narrow suppression; the single-value frame runs out early.
    configure(1, 3, VAL_MIN);
    queue_value(24'sd5, 1'b0);
    queue_value(24'sd5, 1'b0);
    queue_value(24'sd5, 1'b0);
    queue_value(24'sd9, 1'b0);
    queue_value(24'sd1, 1'b0);
    queue_value(24'sd1, 1'b1);
    queue_value(24'sd7, 1'b1);

    // A window of 4096 blocks the whole frame after the first peak.
    configure(4096, 0, VAL_MIN);
    queue_value(24'sd1, 1'b0);
    queue_value(24'sd2, 1'b0);
    queue_value(24'sd3, 1'b1);

    for (phase = 0; phase < 8; phase++) begin
      len = 0;
      case (phase)
        0: begin configure(0, 0, VAL_MIN); send_idle_pct = 0; recv_stall_pct = 0; len = 66; end
        1: begin configure(3, 5, VAL_MAX); send_idle_pct = 83; recv_stall_pct = 0; end
        2: begin configure(1, 0, 24'sd0); send_idle_pct = 0; recv_stall_pct = 83; end
        3: begin configure(0, 100, 24'sd0); send_idle_pct = 26; recv_stall_pct = 26; len = 66; end
        4: begin
          configure(0, 64, VALUE_BITS'($urandom));
          send_idle_pct = 0;
          recv_stall_pct = 0;
          len = 64;
        end
        5: begin configure(4096, 127, -24'sd1); send_idle_pct = 83; recv_stall_pct = 0; end
        6: begin configure(2, 0, VAL_MAX); send_idle_pct = 0; recv_stall_pct = 83; end
        default: begin
          configure($urandom_range(7), $urandom_range(8),
                    $urandom_range(1) ? VALUE_BITS'($urandom) :
                                        $signed(VALUE_BITS'($urandom_range(8000))));
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      // Long frames that reach the detection cap, or exactly the fixed count of 64.
      if (len != 0) queue_frame(len);
      queued = 0;
      while (queued < 12) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 8);
        queue_frame(len);
        queued += len;
        if ($urandom_range(4) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (peak_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", peak_q.size()));
    end
    $display("Run covered %0d frames from %0d requests under %0d register settings,",
             frames_closed, requests_taken, settings_used);
    $display("checking %0d results, with capped and empty frames among them.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
